### sv/tfp_pkg.sv
// ----------------------------------------------------------------------------
// tfp_pkg: shared types and constants of the telemetry frame parser
// Frame layout, status codes, register indexes and the structs that travel
// between the configuration registers, the decoder and the top level.
// ----------------------------------------------------------------------------
package tfp_pkg;

  // Frame layout
  localparam int FRAME_BYTES = 21;
  localparam int IDX_W       = 5;
  localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] START_IDX    = 5'd0;
  localparam logic [IDX_W-1:0] CMD_IDX      = 5'd1;
  localparam logic [IDX_W-1:0] STATE_IDX    = 5'd2;
  localparam logic [IDX_W-1:0] POS_FIRST    = 5'd3;
  localparam logic [IDX_W-1:0] WORD_FIRST   = 5'd7;
  localparam logic [IDX_W-1:0] WORD_LAST_HI = 5'd18;
  localparam int NUM_WORDS  = 6;
  localparam int WORD_SEL_W = 3;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_LEN_ERR  = 2'd1;
  localparam status_t ST_MARK_ERR = 2'd2;
  localparam status_t ST_CMD_ERR  = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TELEM_CODE   = 2'd2;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [7:0] telemetry_code;
  } cfg_t;

  typedef struct packed {
    status_t            status;
    logic [7:0]         board_state;
    logic signed [31:0] position;
    logic signed [15:0] speed;
    logic signed [15:0] total_force;
    logic signed [15:0] fet_temp;
    logic signed [15:0] motor_temp;
    logic signed [15:0] brake_temp;
    logic signed [15:0] bus_voltage;
  } result_t;

endpackage

### sv/telemetry_frame_parser.sv
// ----------------------------------------------------------------------------
// telemetry_frame_parser: byte-serial telemetry response decoder
// Path: an accepted byte is held in the input register and decoded from there;
//   a frame's last byte loads the result register that drives the out_ ports.
// Throughput: one byte per cycle, set by the input register feeding the decode
//   stage; only a stalled result with a pending last byte holds the input.
// Reset (rst_n low, synchronous): clears config registers, counter, flags and valids.
// ----------------------------------------------------------------------------
module telemetry_frame_parser
  import tfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  // byte input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  input  logic                 in_frame_last,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [7:0]           out_board_state,
  output logic signed [31:0]   out_position,
  output logic signed [15:0]   out_speed,
  output logic signed [15:0]   out_total_force,
  output logic signed [15:0]   out_fet_temp,
  output logic signed [15:0]   out_motor_temp,
  output logic signed [15:0]   out_brake_temp,
  output logic signed [15:0]   out_bus_voltage
);

  cfg_t       cfg;
  result_t    dec_res;

  logic       in_vld_r;
  logic       in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       out_vld_r;
  logic       out_vld_nxt;
  result_t    out_res_r;
  logic       in_xfer;
  logic       advance;
  logic       emit;

  assign cfg_ready = 1'b1;

  tfp_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the held byte unless it would produce a result into a full, stalled slot
  assign advance  = in_vld_r && (!in_last_r || !out_vld_r || out_ready);
  assign emit     = advance && in_last_r;
  assign in_ready = !in_vld_r || advance;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_xfer) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Hold the input byte
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_rx_byte;
      in_last_r <= in_frame_last;
    end
  end

  tfp_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .rx_byte    (in_byte_r),
    .frame_last (in_last_r),
    .cfg        (cfg),
    .res        (dec_res)
  );

  // Load the result register on the last byte
  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r <= dec_res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_status      = out_res_r.status;
  assign out_board_state = out_res_r.board_state;
  assign out_position    = out_res_r.position;
  assign out_speed       = out_res_r.speed;
  assign out_total_force = out_res_r.total_force;
  assign out_fet_temp    = out_res_r.fet_temp;
  assign out_motor_temp  = out_res_r.motor_temp;
  assign out_brake_temp  = out_res_r.brake_temp;
  assign out_bus_voltage = out_res_r.bus_voltage;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |-> !emit)
    else $error("result register overwritten while stalled");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !advance) |=> (in_vld_r && $stable(in_byte_r) && $stable(in_last_r)))
    else $error("held byte lost while decode stalled");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_vld_r)
    else $error("result not presented after last byte");

endmodule

### sv/tfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// tfp_cfg_regs: configuration registers of the telemetry frame parser
// Decodes the register index of each write transfer and holds the markers
// and the expected command code. Writes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module tfp_cfg_regs
  import tfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]           wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write index
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_START_MARKER: cfg_nxt.start_marker   = wr_data;
        REG_END_MARKER:   cfg_nxt.end_marker     = wr_data;
        REG_TELEM_CODE:   cfg_nxt.telemetry_code = wr_data;
        default:          cfg_nxt                = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/tfp_decode.sv
// ----------------------------------------------------------------------------
// tfp_decode: byte counter, field capture and status decision
// Tracks the position of each byte in the frame, latches the state byte,
// position and six 16-bit words, and forms the result on the last byte.
// ----------------------------------------------------------------------------
module tfp_decode
  import tfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  logic       frame_last,
  input  cfg_t       cfg,
  output result_t    res
);

  logic [IDX_W-1:0] byte_index_r;
  logic [IDX_W-1:0] byte_index_nxt;
  logic             overlong_r;
  logic             overlong_nxt;
  logic             start_ok_r;
  logic             start_ok_nxt;
  logic             command_ok_r;
  logic             command_ok_nxt;

  logic [7:0]       state_cap_r;
  logic [31:0]      pos_cap_r;
  logic [15:0]      word_cap_r [NUM_WORDS];

  logic [IDX_W-1:0]      word_off;
  logic [WORD_SEL_W-1:0] word_sel;
  logic                  in_pos;
  logic                  in_words;
  logic [1:0]            pos_lane;
  logic                  len_ok;
  logic                  capture;

  assign capture  = step && !overlong_r;
  assign word_off = byte_index_r - WORD_FIRST;
  assign word_sel = word_off[WORD_SEL_W:1];
  assign in_pos   = (byte_index_r >= POS_FIRST) && (byte_index_r < WORD_FIRST);
  assign in_words = (byte_index_r >= WORD_FIRST) && (byte_index_r <= WORD_LAST_HI);
  assign pos_lane = 2'(byte_index_r - POS_FIRST);

  // Advance the byte counter and header flags; rearm after the last byte
  always_comb begin
    byte_index_nxt = byte_index_r;
    overlong_nxt   = overlong_r;
    start_ok_nxt   = start_ok_r;
    command_ok_nxt = command_ok_r;
    if (step) begin
      if (!overlong_r && byte_index_r == START_IDX) begin
        start_ok_nxt = (rx_byte == cfg.start_marker);
      end
      if (!overlong_r && byte_index_r == CMD_IDX) begin
        command_ok_nxt = (rx_byte == cfg.telemetry_code);
      end
      if (frame_last) begin
        byte_index_nxt = '0;
        overlong_nxt   = 1'b0;
        start_ok_nxt   = 1'b0;
        command_ok_nxt = 1'b0;
      end else if (overlong_r || byte_index_r >= LAST_IDX) begin
        byte_index_nxt = LAST_IDX;
        overlong_nxt   = 1'b1;
      end else begin
        byte_index_nxt = byte_index_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      overlong_r   <= 1'b0;
      start_ok_r   <= 1'b0;
      command_ok_r <= 1'b0;
    end else begin
      byte_index_r <= byte_index_nxt;
      overlong_r   <= overlong_nxt;
      start_ok_r   <= start_ok_nxt;
      command_ok_r <= command_ok_nxt;
    end
  end

  // Capture payload bytes at their frame positions
  always_ff @(posedge clk) begin
    if (capture) begin
      if (byte_index_r == STATE_IDX) begin
        state_cap_r <= rx_byte;
      end
      if (in_pos) begin
        pos_cap_r[pos_lane*8 +: 8] <= rx_byte;
      end
      if (in_words) begin
        if (word_off[0]) begin
          word_cap_r[word_sel][15:8] <= rx_byte;
        end else begin
          word_cap_r[word_sel][7:0] <= rx_byte;
        end
      end
    end
  end

  // Status priority: length, then markers, then command
  assign len_ok = !overlong_r && (byte_index_r == LAST_IDX);

  always_comb begin
    res = '0;
    if (!len_ok) begin
      res.status = ST_LEN_ERR;
    end else if (!start_ok_r || rx_byte != cfg.end_marker) begin
      res.status = ST_MARK_ERR;
    end else if (!command_ok_r) begin
      res.status = ST_CMD_ERR;
    end else begin
      res.status      = ST_OK;
      res.board_state = state_cap_r;
      res.position    = pos_cap_r;
      res.speed       = word_cap_r[0];
      res.total_force = word_cap_r[1];
      res.fet_temp    = word_cap_r[2];
      res.motor_temp  = word_cap_r[3];
      res.brake_temp  = word_cap_r[4];
      res.bus_voltage = word_cap_r[5];
    end
  end

  a_overlong_pinned: assert property (@(posedge clk) disable iff (!rst_n)
    overlong_r |-> (byte_index_r == LAST_IDX))
    else $error("overlong frame without counter pinned at last index");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_index_r <= LAST_IDX)
    else $error("byte counter beyond frame length");

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (step && frame_last) |=>
      (byte_index_r == '0 && !overlong_r && !start_ok_r && !command_ok_r))
    else $error("parser not rearmed after last byte");

endmodule
